// ----- sv/mbp_pkg.sv -----
// Shared types and constants for the MSB-first bit packer.
package mbp_pkg;

  localparam int CODE_W          = 32;
  localparam int COUNT_W         = 6;
  localparam int BYTE_W          = 8;
  localparam int MAX_CODE_BITS_D = 32;

  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_ge8;
    logic last;
    logic slot_free;
  } sts_t;

endpackage

// ----- sv/mbp_ctrl.sv -----
// Controller state machine of the MSB-first bit packer.
module mbp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mbp_pkg::sts_t sts_i,
  output mbp_pkg::cmd_t cmd_o
);

  mbp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      mbp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mbp_pkg::ST_EMIT;
        end
      end
      mbp_pkg::ST_EMIT: begin
        if (!sts_i.rem_ge8) begin
          state_d = mbp_pkg::ST_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.push = 1'b1;
          if (sts_i.last) begin
            state_d = mbp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = mbp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/mbp_dp.sv -----
// Datapath of the MSB-first bit packer: bit window, bit count and output register.
module mbp_dp #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS_D
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          operation_i,
  input  logic [mbp_pkg::CODE_W-1:0]    code_i,
  input  logic [mbp_pkg::COUNT_W-1:0]   code_len_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [mbp_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          last_o,
  input  mbp_pkg::cmd_t                 cmd_i,
  output mbp_pkg::sts_t                 sts_o
);

  localparam int AW    = MAX_CODE_BITS + mbp_pkg::BYTE_W;
  localparam int REM_W = $clog2(AW);
  localparam int SH_W  = $clog2(AW + 1);
  localparam int CMP_W = mbp_pkg::COUNT_W + 1;

  // The window holds pending bits left-aligned; everything below them is zero.
  logic [AW-1:0]                acc_q, acc_d;
  logic [REM_W-1:0]             rem_q, rem_d;
  logic                         out_valid_q, out_valid_d;
  logic [mbp_pkg::BYTE_W-1:0]   out_byte_q;
  logic                         last_q;

  logic [REM_W-1:0] cnt_sat;
  logic [AW-1:0]    code_w;
  logic [AW-1:0]    masked;
  logic [SH_W-1:0]  shamt;
  logic             is_last;

  assign code_w = AW'(code_i);

  always_comb begin
    if ({1'b0, code_len_i} > CMP_W'(MAX_CODE_BITS)) begin
      cnt_sat = REM_W'(MAX_CODE_BITS);
    end else begin
      cnt_sat = REM_W'(code_len_i);
    end
  end

  always_comb begin
    for (int k = 0; k < AW; k++) begin
      masked[k] = code_w[k] & (k < int'(cnt_sat));
    end
  end

  // Moves the first code bit to sit right below the pending bits.
  assign shamt = SH_W'(AW) - SH_W'(cnt_sat) - SH_W'(rem_q);

  assign is_last = {1'b0, rem_q} < (REM_W + 1)'(16);

  assign sts_o.rem_ge8   = rem_q >= REM_W'(8);
  assign sts_o.last      = is_last;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    acc_d       = acc_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      if (operation_i == mbp_pkg::OP_FLUSH) begin
        rem_d = (rem_q != '0) ? REM_W'(8) : '0;
      end else begin
        acc_d = acc_q | (masked << shamt);
        rem_d = rem_q + cnt_sat;
      end
    end else if (cmd_i.push) begin
      acc_d       = acc_q << mbp_pkg::BYTE_W;
      rem_d       = rem_q - REM_W'(8);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_byte_q <= acc_q[AW-1 -: mbp_pkg::BYTE_W];
      last_q     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule

// ----- sv/msb_first_bit_packer.sv -----
// Top level of the MSB-first variable-length bit packer.
//
//   Channel | Signals                                   | Direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i, in_ready_o, operation_i,      | in
//           | code_i, code_len_i                        |
//   output  | out_valid_o, out_ready_i, out_byte_o,     | out
//           | last_o                                    |
//
// An input transfer is taken in the idle state and each byte it completes then leaves one per cycle
// while the output register is free; an item completes 0 to 4 bytes at the default code width, and
// the next item waits for that drain; the single byte-wide output register sets this pace.
// Reset clears the pending bits, the bit count, the state and the output valid flag.
// A stalled output holds its byte in the output register and the drain waits; the next input
// transfer is taken once the last byte of the item has entered that register.
module msb_first_bit_packer #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS_D
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [mbp_pkg::CODE_W-1:0]  code_i,
  input  logic [mbp_pkg::COUNT_W-1:0] code_len_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mbp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_o
);

  mbp_pkg::cmd_t cmd;
  mbp_pkg::sts_t sts;

  // The controller sequences the load of an item and the byte-by-byte drain.
  mbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath aligns code bits behind the pending bits and shifts bytes out.
  mbp_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (operation_i),
    .code_i      (code_i),
    .code_len_i  (code_len_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
